>>> rtl/grid_local_maximum_detect_assert.svh
// assertion macros used by the checker file
`ifndef GRID_LOCAL_MAXIMUM_DETECT_ASSERT_SVH
`define GRID_LOCAL_MAXIMUM_DETECT_ASSERT_SVH

// same-cycle implication, disabled while the given reset is low
`define GLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while the given reset is low
`define GLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/glm_pkg.sv
// shared types, constants and helpers for the local maximum detector
package glm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DATA_WIDTH = 16;

  // widths of the port fields
  localparam int POS_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // the delay line holds one row minus one sample
  localparam int LINE_CELLS = MAX_WIDTH - 1;
  localparam int CELL_IDX_W = $clog2(LINE_CELLS);

  // report kinds, in raster order of the cells they name
  localparam int NUM_KINDS  = 3;
  localparam int KIND_ABOVE = 0;
  localparam int KIND_LEFT  = 1;
  localparam int KIND_HERE  = 2;

  // report group queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] sample_t;
  typedef logic [POS_W-1:0]             pos_t;
  typedef logic [CELL_IDX_W-1:0]        cell_idx_t;
  typedef logic [NUM_KINDS-1:0]         kind_mask_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_HEIGHT,
    REG_FRAME_WIDTH
  } cfg_reg_t;

  // one slot of both delay lanes
  typedef struct packed {
    sample_t lane_a;
    sample_t lane_b;
  } line_pair_t;

  // reports released by one sample
  typedef struct packed {
    kind_mask_t kinds;
    pos_t       row;
    pos_t       col;
  } report_grp_t;

  // saturate a size to 2..hi and return size minus one
  function automatic pos_t clamp_last(input logic [CFG_W-1:0] v,
                                      input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] s;
    begin
      if (v < CFG_W'(2)) begin
        s = CFG_W'(2);
      end else if (v > hi) begin
        s = hi;
      end else begin
        s = v;
      end
      clamp_last = POS_W'(s - CFG_W'(1));
    end
  endfunction

endpackage

>>> rtl/glm_cell.sv
// one delay line slot: loads the line input or its left neighbor
module glm_cell
  import glm_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic       load_sel,
  input  line_pair_t din,
  input  line_pair_t prev,
  output line_pair_t q
);

  line_pair_t q_r;
  line_pair_t q_nxt;

  // entry point of the line takes fresh data, the rest shift along
  always_comb begin
    q_nxt = load_sel ? din : prev;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

>>> rtl/glm_line.sv
// row of cells forming two delay lines with a selectable entry point
module glm_line
  import glm_pkg::*;
(
  input  logic      clk,
  input  logic      shift_en,
  input  cell_idx_t ins_idx,
  input  sample_t   din_a,
  input  sample_t   din_b,
  output sample_t   tap_a,
  output sample_t   tap_b
);

  line_pair_t din_pair;
  line_pair_t cell_q [LINE_CELLS];

  assign din_pair = '{lane_a: din_a, lane_b: din_b};

  // the cell at ins_idx takes the input, so the delay is LINE_CELLS - ins_idx
  for (genvar i = 0; i < LINE_CELLS; i++) begin : g_cell
    line_pair_t prev;
    logic       sel;

    if (i == 0) begin : g_head
      assign prev = din_pair;
    end else begin : g_body
      assign prev = cell_q[i-1];
    end

    assign sel = (ins_idx == CELL_IDX_W'(i));

    glm_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .load_sel (sel),
      .din      (din_pair),
      .prev     (prev),
      .q        (cell_q[i])
    );
  end

  // line outputs at the far end
  assign tap_a = cell_q[LINE_CELLS-1].lane_a;
  assign tap_b = cell_q[LINE_CELLS-1].lane_b;

endmodule

>>> rtl/glm_report_q.sv
// queue of report groups, drained one report per beat
module glm_report_q
  import glm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  report_grp_t push_grp,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output pos_t        out_row,
  output pos_t        out_col,
  output logic        out_last
);

  report_grp_t       grp_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  report_grp_t       head;
  kind_mask_t        pick_mask;
  kind_mask_t        kinds_left;
  logic              out_fire;
  logic              pop;
  logic              trim;

  assign head = grp_r[rd_ptr_r];

  // earliest pending report of the head group
  always_comb begin
    if (head.kinds[KIND_ABOVE]) begin
      pick_mask = kind_mask_t'(1) << KIND_ABOVE;
      out_row   = head.row - POS_W'(1);
      out_col   = head.col;
    end else if (head.kinds[KIND_LEFT]) begin
      pick_mask = kind_mask_t'(1) << KIND_LEFT;
      out_row   = head.row;
      out_col   = head.col - POS_W'(1);
    end else begin
      pick_mask = kind_mask_t'(1) << KIND_HERE;
      out_row   = head.row;
      out_col   = head.col;
    end
  end

  assign kinds_left = head.kinds & ~pick_mask;
  assign out_last   = (kinds_left == '0);
  assign out_valid  = (cnt_r != '0);
  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign out_fire   = out_valid && !out_stall;
  assign pop        = out_fire && out_last;
  assign trim       = out_fire && !out_last;

  // group storage; push never lands on the head while it is being trimmed
  always_ff @(posedge clk) begin
    if (push) begin
      grp_r[wr_ptr_r] <= push_grp;
    end
    if (trim) begin
      grp_r[rd_ptr_r].kinds <= kinds_left;
    end
  end

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/grid_local_maximum_detect.sv
// Reports of a sample are written into the report queue when its beat is taken.
// Throughput: one sample per cycle; reports leave one per unstalled cycle from a two-group
// queue, so the input stalls only while that queue is full (bursts of two or three reports).
// The row delay is a chain of 1023 shift cells whose entry point follows frame_width.
// Reset: position to row 0 column 0, sizes to 2 x 2, queue empty; line contents are
// left as they are and never read before being refilled in the same frame.
module grid_local_maximum_detect
  import glm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sample_t              in_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pos_t                 out_peak_row,
  output pos_t                 out_peak_col,
  output logic                 out_last_of_run
);

  pos_t        h_last_r, h_last_nxt;
  pos_t        w_last_r, w_last_nxt;
  cell_idx_t   ins_idx_r, ins_idx_nxt;
  pos_t        row_cnt_r, row_cnt_nxt;
  pos_t        col_cnt_r, col_cnt_nxt;
  sample_t     a1_r, a2_r, left_r, left2_r;
  sample_t     tap_a, tap_b;
  logic        in_fire;
  logic        q_full;
  pos_t        r_cur, c_cur;
  logic        has_above, has_above2, has_left, has_left2, has_right;
  logic        last_row, last_col;
  logic        peak_above, peak_left, peak_here;
  report_grp_t grp;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  // current position, wrapped if it lies beyond the frame
  always_comb begin
    if (row_cnt_r > h_last_r || col_cnt_r > w_last_r) begin
      r_cur = '0;
      c_cur = '0;
    end else begin
      r_cur = row_cnt_r;
      c_cur = col_cnt_r;
    end
  end

  assign has_above  = (r_cur != '0);
  assign has_above2 = (r_cur > POS_W'(1));
  assign has_left   = (c_cur != '0);
  assign has_left2  = (c_cur > POS_W'(1));
  assign has_right  = (c_cur != w_last_r);
  assign last_row   = (r_cur == h_last_r);
  assign last_col   = (c_cur == w_last_r);

  // cell above the sample: below is the sample, left a2, right tap_a, above tap_b
  assign peak_above = has_above && (a1_r >= in_sample)
                   && !(has_above2 && (a1_r < tap_b))
                   && !(has_left && (a1_r < a2_r))
                   && !(has_right && (a1_r < tap_a));

  // last row, cell left of the sample
  assign peak_left = last_row && has_left && (left_r >= in_sample) && (left_r >= a2_r)
                  && !(has_left2 && (left_r < left2_r));

  // last cell of the frame
  assign peak_here = last_row && last_col && (in_sample >= a1_r) && (in_sample >= left_r);

  always_comb begin
    grp.kinds             = '0;
    grp.kinds[KIND_ABOVE] = peak_above;
    grp.kinds[KIND_LEFT]  = peak_left;
    grp.kinds[KIND_HERE]  = peak_here;
    grp.row               = r_cur;
    grp.col               = c_cur;
  end

  // row delay: lane a gives w-1 beats, lane b adds w-1 more after a2
  glm_line u_line (
    .clk      (clk),
    .shift_en (in_fire),
    .ins_idx  (ins_idx_r),
    .din_a    (in_sample),
    .din_b    (a2_r),
    .tap_a    (tap_a),
    .tap_b    (tap_b)
  );

  // short taps around the line end and along the current row
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a1_r    <= tap_a;
      a2_r    <= a1_r;
      left_r  <= in_sample;
      left2_r <= left_r;
    end
  end

  // frame sizes and position
  always_comb begin
    h_last_nxt  = h_last_r;
    w_last_nxt  = w_last_r;
    ins_idx_nxt = ins_idx_r;
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_HEIGHT: begin
          h_last_nxt = clamp_last(cfg_data, CFG_W'(MAX_HEIGHT));
        end
        REG_FRAME_WIDTH: begin
          w_last_nxt  = clamp_last(cfg_data, CFG_W'(MAX_WIDTH));
          ins_idx_nxt = CELL_IDX_W'(LINE_CELLS)
                      - CELL_IDX_W'(clamp_last(cfg_data, CFG_W'(MAX_WIDTH)));
        end
        default: begin
          h_last_nxt = h_last_r;
        end
      endcase
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : r_cur + POS_W'(1);
      end else begin
        col_cnt_nxt = c_cur + POS_W'(1);
        row_cnt_nxt = r_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_last_r  <= POS_W'(1);
      w_last_r  <= POS_W'(1);
      ins_idx_r <= CELL_IDX_W'(LINE_CELLS - 1);
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      h_last_r  <= h_last_nxt;
      w_last_r  <= w_last_nxt;
      ins_idx_r <= ins_idx_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // report queue
  glm_report_q u_report_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && (grp.kinds != '0)),
    .push_grp  (grp),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_peak_row),
    .out_col   (out_peak_col),
    .out_last  (out_last_of_run)
  );

endmodule

>>> rtl/glm_checker.sv
// port-level checks for the local maximum detector and their bind
`include "grid_local_maximum_detect_assert.svh"

module glm_checker
  import glm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input pos_t out_peak_row,
  input pos_t out_peak_col,
  input logic out_last_of_run
);

  // a stalled report beat holds
  `GLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_peak_row) && $stable(out_peak_col) && $stable(out_last_of_run), "stalled report changed")

  // the input only stalls behind pending reports
  `GLM_ASSERT_NOW(a_stall_needs_reports, clk, rst_n, in_stall, out_valid, "input stalled with no report pending")

  // a full queue stays full until a report leaves
  `GLM_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_stall && out_stall, in_stall, "stall released without a report beat")

  // reset empties the report queue
  `GLM_ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, !out_valid && !in_stall, "reports pending after reset")

endmodule

bind grid_local_maximum_detect glm_checker u_glm_checker (.*);

>>> tb/tb_grid_local_maximum_detect.sv
// self-checking testbench for the streaming 4-neighbour local maximum detector
module tb_grid_local_maximum_detect
  import glm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 140;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  typedef struct packed {
    pos_t row;
    pos_t col;
    logic run_end;
  } peak_rpt_t;

  // predicts the reports of each sample beat and checks them in order
  class peak_scoreboard;
    sample_t          line_above[MAX_WIDTH];
    sample_t          line_prev[MAX_WIDTH];
    int unsigned      row_pos;
    int unsigned      col_pos;
    sample_t          left1;
    sample_t          left2;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] width_reg;
    peak_rpt_t        expected_peaks[$];
    int               errors;

    function new();
      row_pos    = 0;
      col_pos    = 0;
      left1      = '0;
      left2      = '0;
      height_reg = CFG_W'(2);
      width_reg  = CFG_W'(2);
      errors     = 0;
    endfunction

    // one line per mismatch, capped to keep the log short
    task report_mismatch(string msg);
      if (errors < 200) $display("mismatch: %s", msg);
      errors++;
    endtask

    function int unsigned fit_size(logic [CFG_W-1:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
    endfunction

    // a register write restarts the frame
    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_FRAME_HEIGHT: height_reg = v;
        REG_FRAME_WIDTH:  width_reg = v;
        default: ;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int pending();
      return expected_peaks.size();
    endfunction

    // work out the peaks released by one accepted sample
    function void predict_peaks(sample_t s);
      int unsigned h;
      int unsigned w;
      int unsigned r;
      int unsigned c;
      peak_rpt_t   found[$];
      sample_t     v;
      bit          hit;
      h = fit_size(height_reg, MAX_HEIGHT);
      w = fit_size(width_reg, MAX_WIDTH);
      r = row_pos;
      c = col_pos;
      if (r >= h || c >= w) begin
        r = 0;
        c = 0;
      end
      // the cell above is decided by its lower neighbour
      if (r >= 1) begin
        v = line_prev[c];
        hit = (v >= s);
        if (r >= 2 && v < line_above[c]) hit = 1'b0;
        if (c >= 1 && v < line_above[c-1]) hit = 1'b0;
        if (c + 1 < w && v < line_prev[c+1]) hit = 1'b0;
        if (hit) found.push_back('{row: pos_t'(r - 1), col: pos_t'(c), run_end: 1'b0});
      end
      line_above[c] = line_prev[c];
      line_prev[c]  = s;
      // in the last row the left cell is decided by its right neighbour
      if (r == h - 1) begin
        if (c >= 1) begin
          v = left1;
          hit = (v >= s) && (v >= line_above[c-1]);
          if (c >= 2 && v < left2) hit = 1'b0;
          if (hit) found.push_back('{row: pos_t'(r), col: pos_t'(c - 1), run_end: 1'b0});
        end
        // bottom right corner is decided on arrival
        if (c == w - 1) begin
          hit = (s >= line_above[c]) && (s >= left1);
          if (hit) found.push_back('{row: pos_t'(r), col: pos_t'(c), run_end: 1'b0});
        end
      end
      left2 = left1;
      left1 = s;
      // advance the raster position, wrapping at the end of the frame
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
      if (found.size() > 0) found[found.size()-1].run_end = 1'b1;
      foreach (found[i]) expected_peaks.push_back(found[i]);
    endfunction

    // compare one report beat with the oldest expected peak
    task check_peak(pos_t row, pos_t col, logic run_end);
      peak_rpt_t want;
      if (expected_peaks.size() == 0) begin
        report_mismatch($sformatf("unexpected peak row %0d col %0d last %0d",
                                  row, col, run_end));
      end else begin
        want = expected_peaks.pop_front();
        if (row !== want.row || col !== want.col || run_end !== want.run_end)
          report_mismatch($sformatf("peak row %0d col %0d last %0d, want %0d %0d %0d",
                                    row, col, run_end, want.row, want.col,
                                    want.run_end));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sample_t              in_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pos_t                 out_peak_row;
  pos_t                 out_peak_col;
  logic                 out_last_of_run;

  peak_scoreboard peak_sb;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             cycle_count = 0;

  grid_local_maximum_detect dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_peak_row   (out_peak_row),
    .out_peak_col   (out_peak_col),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: check each report beat, then choose the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      peak_sb.check_peak(out_peak_row, out_peak_col, out_last_of_run);
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 85; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 85; end
      default:       begin idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  // offer one sample beat and wait until it is taken
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    peak_sb.predict_peaks(s);
  endtask

  // stop sending and wait for every expected peak plus a few quiet cycles
  task automatic drain();
    in_valid <= 1'b0;
    while (peak_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // size register writes, height first; only while the block is idle
  task automatic configure(bit wr_h, logic [CFG_W-1:0] h, bit wr_w, logic [CFG_W-1:0] w);
    if (wr_h) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_data  <= h;
      @(posedge clk);
      peak_sb.write_reg(REG_FRAME_HEIGHT, h);
    end
    if (wr_w) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_data  <= w;
      @(posedge clk);
      peak_sb.write_reg(REG_FRAME_WIDTH, w);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // full range, small values for ties, or the extremes
  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0, 1:    return sample_t'($urandom);
      2:       return sample_t'(int'($urandom_range(6)) - 3);
      default: begin
        case ($urandom_range(2))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // mostly small frames, sometimes sizes below range or a bit larger
  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(9))
      0:       return CFG_W'($urandom_range(1));
      1:       return CFG_W'($urandom_range(7, 40));
      default: return CFG_W'($urandom_range(2, 6));
    endcase
  endfunction

  initial begin
    static sample_t ties_2x2[4]  = '{16'sd5, 16'sd5, 16'sd5, 16'sd5};
    static sample_t ends_2x2[4]  = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
    static sample_t mixed_3x3[9] = '{16'sd0, -16'sd1, 16'sh7fff, 16'sh8000, 16'sd100,
                                     16'sd100, 16'sh7fff, 16'sh8000, 16'sd0};
    static sample_t low_2x2[4]   = '{-16'sd1, -16'sd1, -16'sd2, -16'sd1};
    int      rand_items;
    int      phase;
    int      n;
    int      sel;

    peak_sb = new();
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default 2x2 sizes, all ties then extremes across a frame wrap
    foreach (ties_2x2[i]) send_sample(ties_2x2[i]);
    foreach (ends_2x2[i]) send_sample(ends_2x2[i]);
    drain();
    configure(1'b1, CFG_W'(3), 1'b1, CFG_W'(3));
    foreach (mixed_3x3[i]) send_sample(mixed_3x3[i]);
    drain();
    // sizes below range saturate to two
    configure(1'b1, CFG_W'(1), 1'b1, CFG_W'(0));
    foreach (low_2x2[i]) send_sample(low_2x2[i]);
    drain();

    // random frames with random sizes and idling
    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      set_idling(idling_t'(phase % 4));
      sel = $urandom_range(3);
      configure(sel[0], pick_size(), sel[1], pick_size());
      n = $urandom_range(4, 60);
      for (int i = 0; i < n; i++) begin
        send_sample(rand_sample());
        // pause mid-stream until every expected peak is out
        if (phase == 1 && i == n / 2) drain();
      end
      rand_items += n;
      phase++;
      drain();
    end

    // oversized height register saturates; a few rows of a tall frame
    set_idling(IDLE_BOTH);
    configure(1'b1, CFG_W'(2047), 1'b1, CFG_W'(3));
    repeat (15) send_sample(rand_sample());
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (peak_sb.errors == 0 && peak_sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
